// ===== sv/bra_pkg.sv =====
// Shared constants, codes and word-level helper functions for the bitmap range allocator.
package bra_pkg;

	localparam int NBITS     = 1024;
	localparam int WORD_BITS = 64;
	localparam int NWORDS    = (NBITS + WORD_BITS - 1) / WORD_BITS;
	localparam int IDX_W     = 11;
	localparam int WADDR_W   = $clog2(NWORDS);
	localparam int WOFF_W    = $clog2(WORD_BITS);
	localparam int CNT_W     = WOFF_W + 1;

	localparam logic [IDX_W-1:0] NBITS_IDX = IDX_W'(NBITS);

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [CNT_W-1:0]     cnt_t;

	typedef enum logic [1:0] {
		OP_FIND_SET  = 2'd0,
		OP_CLEAR     = 2'd1,
		OP_SET       = 2'd2,
		OP_FIND_FREE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	// Bounds above the bitmap length are clipped to it.
	function automatic idx_t sat_bound(input idx_t v);
		return (v > NBITS_IDX) ? NBITS_IDX : v;
	endfunction

	// Index of the lowest set bit, or WORD_BITS when the word is zero.
	function automatic cnt_t ctz(input word_t v);
		cnt_t r;
		r = CNT_W'(WORD_BITS);
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (v[i])
				r = CNT_W'(i);
		end
		return r;
	endfunction

	function automatic word_t reverse(input word_t v);
		word_t r;
		for (int i = 0; i < WORD_BITS; i++)
			r[i] = v[WORD_BITS-1-i];
		return r;
	endfunction

	// Bits of the word whose global index lies in [lo, hi).
	function automatic word_t range_mask(input idx_t base, input idx_t lo, input idx_t hi);
		word_t           m;
		logic [IDX_W:0]  pos;
		for (int j = 0; j < WORD_BITS; j++) begin
			pos  = {1'b0, base} + (IDX_W+1)'(j);
			m[j] = (pos >= {1'b0, lo}) && (pos < {1'b0, hi});
		end
		return m;
	endfunction

endpackage

// ===== sv/bitmap_range_allocator.sv =====
// Bitmap range allocator: word-serial find-set, clear, set and free-region search.
//
// The bitmap of NBITS bits is held as NWORDS words of 64 bits, all clear after reset, and
// every request is handled by one word-wide unit that visits one word per cycle, starting
// at word zero. A request is accepted in ST_IDLE, then visits words in ST_RUN (at most
// NWORDS, 16 here; a search stops at the word where it succeeds, a free-region request of
// length zero visits none), then waits in ST_DONE until its result can enter the output
// register; only then is a new request accepted. Clear and set always visit every word.
// The input word carries the request code in s_tuser; every request yields exactly one
// output word, which holds the found index, or zero for clear and set. bitmap_size may be
// written only while no request is in flight.
module bitmap_range_allocator
	import bra_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [10:0] cfg_wr_data,  // bitmap_size
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,      // range_start[10:0], range_end[21:11], region_length[32:22]
	input  logic [1:0]  s_tuser,      // req_type[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata       // found_index[10:0]
);

	word_t              bm_q [NWORDS];
	state_t             state_q;
	op_t                op_q;
	logic [WADDR_W-1:0] w_q;
	idx_t               lo_q, hi_q, len_q, size_q, run_q, res_q;
	logic               m_valid_q;
	idx_t               m_data_q;

	// Per-word datapath signals.
	word_t          word, rmask, fmask, bp, free_w;
	idx_t           base, size_sat, res_nx, run_nx;
	cnt_t           tz, lzc, fz;
	logic [IDX_W:0] run_sum;
	logic           last, done, wr_en;
	word_t          wr_word;
	word_t          win [WOFF_W+1];
	logic [2:0]     win_k;
	logic [WOFF_W:0] win_sh;

	wire s_acc = s_tvalid && s_tready;
	wire op_t s_op = op_t'(s_tuser);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(16-IDX_W){1'b0}}, m_data_q};

	always_comb begin
		word     = bm_q[w_q];
		base     = IDX_W'({w_q, {WOFF_W{1'b0}}});
		last     = (w_q == WADDR_W'(NWORDS - 1));
		size_sat = sat_bound(size_q);
		rmask    = range_mask(base, lo_q, hi_q);
		fmask    = word & rmask;

		// Positions at or above bitmap_size count as taken for the free search.
		bp  = word | ~range_mask(base, '0, size_sat);
		tz  = ctz(bp);
		lzc = ctz(reverse(bp));

		// win[k] marks the starts of 2**k clear bits inside the word; zeros come in from the
		// top, so a window that would leave the word is never free here. A window of len bits
		// is two overlapping windows of the largest power of two not above len.
		win[0] = ~bp;
		for (int k = 1; k <= WOFF_W; k++)
			win[k] = win[k-1] & (win[k-1] >> (1 << (k-1)));
		win_k = '0;
		for (int k = 0; k <= WOFF_W; k++) begin
			if (len_q[k])
				win_k = 3'(k);
		end
		win_sh  = (WOFF_W+1)'(len_q) - ((WOFF_W+1)'(1) << win_k);
		free_w  = win[win_k] & (win[win_k] >> win_sh);
		fz      = ctz(free_w);
		run_sum = {1'b0, run_q} + (IDX_W+1)'(tz);
		run_nx  = (bp == '0) ? (run_q + IDX_W'(WORD_BITS)) : IDX_W'(lzc);

		done    = 1'b0;
		res_nx  = '0;
		wr_en   = 1'b0;
		wr_word = word;
		case (op_q)
			OP_FIND_SET: begin
				if (fmask != '0) begin
					done   = 1'b1;
					res_nx = base + IDX_W'(ctz(fmask));
				end else if (last) begin
					done   = 1'b1;
					res_nx = hi_q;
				end
			end
			OP_CLEAR: begin
				wr_en   = 1'b1;
				wr_word = word & ~rmask;
				done    = last;
			end
			OP_SET: begin
				wr_en   = 1'b1;
				wr_word = word | rmask;
				done    = last;
			end
			default: begin
				// A run carried in from lower words beats anything starting in this word.
				if (run_q != '0 && run_sum >= {1'b0, len_q}) begin
					done   = 1'b1;
					res_nx = base - run_q;
				end else if (len_q <= IDX_W'(WORD_BITS) && free_w != '0) begin
					done   = 1'b1;
					res_nx = base + IDX_W'(fz);
				end else if (last) begin
					done   = 1'b1;
					res_nx = size_sat;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NWORDS; i++)
				bm_q[i] <= '0;
		end else if (state_q == ST_RUN && wr_en) begin
			bm_q[w_q] <= wr_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= NBITS_IDX;
		end else if (cfg_wr_en) begin
			size_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
			w_q       <= '0;
		end else begin
			if (state_q == ST_DONE && (!m_valid_q || m_tready))
				m_valid_q <= 1'b1;
			else if (m_valid_q && m_tready)
				m_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						w_q <= '0;
						if (s_op == OP_FIND_FREE && s_tdata[32:22] == '0)
							state_q <= ST_DONE;
						else
							state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (done)
						state_q <= ST_DONE;
					else
						w_q <= w_q + WADDR_W'(1);
				end
				ST_DONE: begin
					if (!m_valid_q || m_tready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Request and result payload.
	always_ff @(posedge clk) begin
		if (s_acc) begin
			op_q  <= s_op;
			lo_q  <= sat_bound(s_tdata[10:0]);
			hi_q  <= sat_bound(s_tdata[21:11]);
			len_q <= s_tdata[32:22];
			run_q <= '0;
			res_q <= '0;
		end else if (state_q == ST_RUN) begin
			run_q <= run_nx;
			if (done)
				res_q <= res_nx;
		end
		if (state_q == ST_DONE && (!m_valid_q || m_tready))
			m_data_q <= res_q;
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> !s_tready)
		else $error("request accepted while a previous request was still in progress");

	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[10:0] <= NBITS_IDX))
		else $error("found index beyond the bitmap");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_DONE))
		else $error("result word presented without a finished request");

endmodule

// ===== tb/alloc_checker.sv =====
// Checker for the bitmap range allocator: mirrors the bitmap, predicts and compares every result.
module alloc_checker
	import bra_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [10:0] cfg_wr_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,      // range_start[10:0], range_end[21:11], region_length[32:22]
	input  logic [1:0]  s_tuser,      // req_type[1:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,      // found_index[10:0]
	output int          fail_count,
	output int          outstanding
);

	logic [NBITS-1:0] shadow_map;
	idx_t             shadow_size;
	idx_t             expected_index_q[$];
	idx_t             want_index;

	function automatic idx_t clip(input idx_t v);
		return (v > idx_t'(NBITS)) ? idx_t'(NBITS) : v;
	endfunction

	// Applies one request to the shadow bitmap and returns the index the block should report.
	function automatic idx_t apply_request(input op_t op, input idx_t start_raw,
			input idx_t stop_raw, input idx_t len);
		int   lo;
		int   hi;
		int   limit;
		int   run;
		bit   hit;
		idx_t res;
		lo    = int'(clip(start_raw));
		hi    = int'(clip(stop_raw));
		limit = int'(clip(shadow_size));
		run   = 0;
		hit   = 1'b0;
		res   = '0;
		case (op)
		OP_FIND_SET: begin
			res = idx_t'(hi);
			for (int i = lo; i < hi; i++) begin
				if (!hit && shadow_map[i]) begin
					res = idx_t'(i);
					hit = 1'b1;
				end
			end
		end
		OP_CLEAR: begin
			for (int i = lo; i < hi; i++)
				shadow_map[i] = 1'b0;
		end
		OP_SET: begin
			for (int i = lo; i < hi; i++)
				shadow_map[i] = 1'b1;
		end
		default: begin
			// A zero length fits anywhere, so the search reports the start of the bitmap.
			if (len == '0) begin
				res = '0;
			end else begin
				res = idx_t'(limit);
				for (int i = 0; i < limit; i++) begin
					if (!hit) begin
						if (shadow_map[i]) begin
							run = 0;
						end else begin
							run++;
							if (run >= int'(len)) begin
								res = idx_t'(i + 1 - int'(len));
								hit = 1'b1;
							end
						end
					end
				end
			end
		end
		endcase
		return res;
	endfunction

	task automatic report_mismatch(input string what, input idx_t got, input idx_t wanted);
		$display("mismatch at %0t: %s, got %0d, expected %0d", $time, what, got, wanted);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_map  = '0;
			shadow_size = idx_t'(NBITS);
			expected_index_q.delete();
			outstanding = 0;
			fail_count  = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_index_q.size() == 0) begin
					report_mismatch("output word with no request waiting", m_tdata[IDX_W-1:0], '0);
				end else begin
					want_index = expected_index_q.pop_front();
					if (m_tdata[IDX_W-1:0] !== want_index)
						report_mismatch("found_index", m_tdata[IDX_W-1:0], want_index);
				end
			end
			if (cfg_wr_en)
				shadow_size = cfg_wr_data;
			if (s_tvalid && s_tready)
				expected_index_q.push_back(apply_request(op_t'(s_tuser), s_tdata[10:0],
					s_tdata[21:11], s_tdata[32:22]));
			outstanding = expected_index_q.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// Top of the bitmap range allocator testbench: clock, reset, stimulus and the final verdict.
module tb_top;
	import bra_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int LONG_HOLD      = 400;
	localparam int BLOCK_ITEMS    = 104;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [10:0] cfg_wr_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;

	int fail_count;
	int outstanding;
	int tx_idle_pct = 30;
	int rx_idle_pct = 49;
	bit hold_req    = 1'b0;

	idx_t size_plan[12] = '{11'd1024, 11'd0, 11'd2047, 11'd1, 11'd700, 11'd1023,
		11'd64, 11'd1025, 11'd333, 11'd1024, 11'd130, 11'd517};

	bitmap_range_allocator u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

	alloc_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Result side: random back-pressure, plus one long hold-off when asked for.
	initial begin : result_sink
		int hold_left;
		hold_left = 0;
		m_tready  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = LONG_HOLD;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// Called at a falling edge; returns at the falling edge after the word is taken.
	task automatic push_req(input op_t op, input idx_t start_i, input idx_t stop_i,
			input idx_t len);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {7'b0, len, stop_i, start_i};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		wait (outstanding == 0);
		@(negedge clk);
	endtask

	task automatic write_size(input idx_t v);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	// Mostly short windows so set and clear leave a fragmented map for the searches to walk.
	task automatic push_random();
		op_t  op;
		idx_t a;
		idx_t b;
		idx_t len;
		int   shape;
		op    = op_t'($urandom_range(3));
		shape = $urandom_range(99);
		if (shape < 70) begin
			a = idx_t'($urandom_range(1023));
			b = a + idx_t'($urandom_range(150));
		end else if (shape < 85) begin
			a = idx_t'($urandom_range(2047));
			b = idx_t'($urandom_range(2047));
		end else if (shape < 93) begin
			a = idx_t'($urandom_range(1100));
			b = idx_t'($urandom_range(a));
		end else begin
			a = idx_t'(64 * $urandom_range(15));
			b = a + idx_t'(64 * $urandom_range(1, 4));
		end
		shape = $urandom_range(99);
		if (shape < 75)
			len = idx_t'($urandom_range(1, 48));
		else if (shape < 90)
			len = idx_t'($urandom_range(49, 300));
		else if (shape < 96)
			len = idx_t'($urandom_range(2047));
		else
			len = '0;
		push_req(op, a, b, len);
	endtask

	initial begin : stimulus
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = OP_FIND_SET;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		push_req(OP_FIND_SET,  11'd0,    11'd1024, 11'd0);
		push_req(OP_FIND_SET,  11'd2047, 11'd2047, 11'd2047);
		push_req(OP_FIND_FREE, 11'd0,    11'd0,    11'd0);
		push_req(OP_FIND_FREE, 11'd2047, 11'd2047, 11'd1024);
		push_req(OP_FIND_FREE, 11'd0,    11'd0,    11'd2047);
		push_req(OP_SET,       11'd0,    11'd1,    11'd2047);
		push_req(OP_SET,       11'd1023, 11'd2047, 11'd0);
		push_req(OP_FIND_SET,  11'd0,    11'd2047, 11'd0);
		push_req(OP_FIND_SET,  11'd1,    11'd1024, 11'd0);
		push_req(OP_CLEAR,     11'd5,    11'd3,    11'd0);
		push_req(OP_SET,       11'd64,   11'd128,  11'd0);
		push_req(OP_FIND_SET,  11'd1,    11'd2047, 11'd0);
		push_req(OP_FIND_FREE, 11'd0,    11'd0,    11'd1024);
		push_req(OP_FIND_FREE, 11'd0,    11'd0,    11'd63);
		push_req(OP_FIND_FREE, 11'd0,    11'd0,    11'd64);
		push_req(OP_SET,       11'd700,  11'd700,  11'd0);
		push_req(OP_CLEAR,     11'd0,    11'd2047, 11'd0);
		push_req(OP_SET,       11'd2047, 11'd0,    11'd0);
		push_req(OP_FIND_SET,  11'd0,    11'd0,    11'd0);
		push_req(OP_FIND_FREE, 11'd0,    11'd0,    11'd1);
		push_req(OP_SET,       11'd1000, 11'd1500, 11'd0);
		push_req(OP_FIND_FREE, 11'd0,    11'd0,    11'd1000);
		push_req(OP_FIND_FREE, 11'd0,    11'd0,    11'd1001);
		push_req(OP_FIND_SET,  11'd0,    11'd1500, 11'd0);
		push_req(OP_CLEAR,     11'd0,    11'd2047, 11'd0);
		drain();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
			0: begin
				tx_idle_pct = 30;
				rx_idle_pct = 49;
			end
			1: begin
				tx_idle_pct = 49;
				rx_idle_pct = 30;
			end
			default: begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			endcase
			for (int blk = 0; blk < 4; blk++) begin
				write_size(size_plan[phase * 4 + blk]);
				for (int n = 0; n < BLOCK_ITEMS; n++) begin
					// The sink stops while words keep coming, so the block backs up to its input.
					if (phase == 2 && blk == 1 && n == 20)
						hold_req = 1'b1;
					push_random();
				end
				drain();
			end
		end

		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
